// ===== sv/ufpd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the form-encoded pair decoder.
// No dependencies; imported by every module of the block.
package ufpd_pkg;

	// Result kinds as seen on the kind port.
	localparam logic [1:0] KIND_NAME     = 2'd0;
	localparam logic [1:0] KIND_VALUE    = 2'd1;
	localparam logic [1:0] KIND_PAIR_END = 2'd2;
	localparam logic [1:0] KIND_DONE     = 2'd3;

	// One queue entry: a single result, or a pair end that is followed by done.
	typedef struct packed {
		logic       two;
		logic [1:0] kind;
		logic [7:0] data;
		logic       has_value;
	} ufpd_entry_t;

endpackage

// ===== sv/ufpd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input bytes, tracks pair and escape state, and queues results.
// Depends on ufpd_pkg.
module ufpd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic                  func,
	input  logic [7:0]            text_byte,
	input  logic                  q_full,
	output logic                  q_push,
	output ufpd_pkg::ufpd_entry_t q_entry
);
	import ufpd_pkg::*;

	localparam logic [1:0] PH_SKIP  = 2'd0;
	localparam logic [1:0] PH_NAME  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;

	localparam logic [1:0] ESC_NONE   = 2'd0;
	localparam logic [1:0] ESC_FIRST  = 2'd1;
	localparam logic [1:0] ESC_SECOND = 2'd2;

	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CASE_MASK  = 8'hDF;

	// Unchecked hex digit: letters fold to upper case, everything else is c - '0'.
	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		logic [7:0] v;
		begin
			if (c >= CH_UPPER_A) begin
				v = (c & CASE_MASK) + 8'd10 - CH_UPPER_A;
			end else begin
				v = c - CH_ZERO;
			end
			return v[3:0];
		end
	endfunction

	logic [1:0] phase_q;
	logic [1:0] esc_q;
	logic [3:0] high_nibble_q;

	logic       accept;
	logic       is_end;
	logic       is_sep;
	logic [1:0] ph;
	logic [1:0] ph_eff;
	logic [7:0] dec_byte;
	logic [1:0] phase_d;
	logic [1:0] esc_d;
	logic [3:0] high_nibble_d;
	logic [1:0] data_kind;

	assign accept = push && !q_full;
	assign is_end = func || (text_byte == 8'd0);
	assign is_sep = (text_byte == CH_AMP) || (text_byte == CH_SEMI);
	assign ph     = (phase_q == PH_NAME || phase_q == PH_VALUE) ? phase_q : PH_SKIP;
	assign ph_eff = (ph == PH_SKIP) ? PH_NAME : ph;
	assign dec_byte  = {high_nibble_q, hex_nibble(text_byte)};
	assign data_kind = (ph_eff == PH_VALUE) ? KIND_VALUE : KIND_NAME;

	// Classify one byte: next state and the result it produces, if any.
	always_comb begin
		phase_d       = phase_q;
		esc_d         = esc_q;
		high_nibble_d = high_nibble_q;
		q_push        = 1'b0;
		q_entry       = '0;
		priority if (is_end) begin
			phase_d       = PH_SKIP;
			esc_d         = ESC_NONE;
			high_nibble_d = 4'd0;
			q_push        = accept;
			if (ph != PH_SKIP) begin
				q_entry.two       = 1'b1;
				q_entry.kind      = KIND_PAIR_END;
				q_entry.has_value = (ph == PH_VALUE);
			end else begin
				q_entry.kind = KIND_DONE;
			end
		end else if (ph == PH_SKIP && (is_sep || text_byte == CH_SPACE)) begin
			phase_d = phase_q;
		end else if (is_sep) begin
			phase_d           = PH_SKIP;
			esc_d             = ESC_NONE;
			high_nibble_d     = 4'd0;
			q_push            = accept;
			q_entry.kind      = KIND_PAIR_END;
			q_entry.has_value = (ph_eff == PH_VALUE);
		end else if (ph_eff == PH_NAME && text_byte == CH_EQUALS) begin
			phase_d       = PH_VALUE;
			esc_d         = ESC_NONE;
			high_nibble_d = 4'd0;
		end else if (esc_q == ESC_FIRST) begin
			phase_d       = ph_eff;
			high_nibble_d = hex_nibble(text_byte);
			esc_d         = ESC_SECOND;
		end else if (esc_q == ESC_SECOND) begin
			phase_d       = ph_eff;
			esc_d         = ESC_NONE;
			high_nibble_d = 4'd0;
			q_push        = accept && (dec_byte != CH_CR);
			q_entry.kind  = data_kind;
			q_entry.data  = dec_byte;
		end else if (text_byte == CH_PERCENT) begin
			phase_d       = ph_eff;
			esc_d         = ESC_FIRST;
			high_nibble_d = 4'd0;
		end else begin
			phase_d      = ph_eff;
			esc_d        = ESC_NONE;
			q_push       = accept;
			q_entry.kind = data_kind;
			q_entry.data = (text_byte == CH_PLUS) ? CH_SPACE : text_byte;
		end
	end

	// Decoder state advances on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_SKIP;
			esc_q         <= ESC_NONE;
			high_nibble_q <= 4'd0;
		end else if (accept) begin
			phase_q       <= phase_d;
			esc_q         <= esc_d;
			high_nibble_q <= high_nibble_d;
		end
	end

	// The escape counter only ever steps through its three defined codes.
	a_esc_code: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != 2'd3) else $error("escape counter reached an undefined code");

	// A pending escape always belongs to a pair.
	a_esc_in_pair: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != ESC_NONE |-> (phase_q == PH_NAME || phase_q == PH_VALUE))
		else $error("escape pending outside a pair");

endmodule

// ===== sv/ufpd_queue.sv =====
`timescale 1ns / 1ps
// Short queue of result entries between the front and back ends.
// Depends on ufpd_pkg.
module ufpd_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  ufpd_pkg::ufpd_entry_t wr_entry,
	output logic                  full,
	input  logic                  rd_en,
	output ufpd_pkg::ufpd_entry_t rd_entry,
	output logic                  q_empty
);
	import ufpd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	ufpd_entry_t   slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_fire;
	logic          rd_fire;

	assign wr_fire  = wr_en && !full;
	assign rd_fire  = rd_en && !q_empty;
	assign full     = (count_q == CW'(DEPTH));
	assign q_empty  = (count_q == '0);
	assign rd_entry = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			slot_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers wrap at the last slot; a separate count tells full from empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Occupancy never exceeds the number of slots.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("queue occupancy out of range");

endmodule

// ===== sv/ufpd_back.sv =====
`timescale 1ns / 1ps
// Back end: expands queue entries into result beats held in an output register.
// Depends on ufpd_pkg.
module ufpd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  ufpd_pkg::ufpd_entry_t q_entry,
	output logic                  q_pop,
	input  logic                  pop,
	output logic                  empty,
	output logic [1:0]            kind,
	output logic [7:0]            out_byte,
	output logic                  has_value,
	output logic                  last
);
	import ufpd_pkg::*;

	logic       out_valid_q;
	logic       done_pending_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic       has_value_q;
	logic       last_q;
	logic       load;

	assign load  = !out_valid_q || pop;
	assign q_pop = load && !done_pending_q && !q_empty;

	assign empty     = !out_valid_q;
	assign kind      = kind_q;
	assign out_byte  = byte_q;
	assign has_value = has_value_q;
	assign last      = last_q;

	// Output control: a two-result entry leaves a done beat pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			done_pending_q <= 1'b0;
		end else if (load) begin
			if (done_pending_q) begin
				out_valid_q    <= 1'b1;
				done_pending_q <= 1'b0;
			end else begin
				out_valid_q    <= !q_empty;
				done_pending_q <= !q_empty && q_entry.two;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			if (done_pending_q) begin
				kind_q      <= KIND_DONE;
				byte_q      <= 8'd0;
				has_value_q <= 1'b0;
				last_q      <= 1'b1;
			end else if (!q_empty) begin
				kind_q      <= q_entry.kind;
				byte_q      <= q_entry.data;
				has_value_q <= q_entry.has_value;
				last_q      <= !q_entry.two;
			end
		end
	end

	// A pending done beat sits behind a shown pair end that is not the last beat.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		done_pending_q |-> (out_valid_q && kind_q == KIND_PAIR_END && !last_q))
		else $error("done pending without a pair end on the output");

	// While a done beat is pending no new entry is taken from the queue.
	a_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		done_pending_q |-> !q_pop) else $error("queue popped while done pending");

endmodule

// ===== sv/url_form_pair_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the streaming form-encoded name/value pair decoder.
// Depends on ufpd_pkg, ufpd_front, ufpd_queue and ufpd_back.

// One input byte is accepted per cycle whenever full is low. The front
// decodes an accepted byte into the queue at the accepting edge, and the back
// end moves the entry into the output register once that register is empty
// or being popped. The output side delivers one beat per cycle while pop is
// held and results wait. Most bytes cause at most one result; the end
// of a string inside a pair causes two (pair end, then done), which occupy
// one queue slot but two output beats, so sustained input rate is one byte
// per cycle except when results are produced faster than the output side takes
// them, in which case the QUEUE_DEPTH-entry queue fills and full is raised.
module url_form_pair_decoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       func,
	input  logic [7:0] text_byte,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       has_value,
	output logic       last
);
	import ufpd_pkg::*;

	logic        q_push;
	ufpd_entry_t wr_entry;
	logic        q_full;
	logic        q_pop;
	ufpd_entry_t rd_entry;
	logic        q_empty;

	assign full = q_full;

	// Byte classification and decoder state.
	ufpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.func      (func),
		.text_byte (text_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (wr_entry)
	);

	// Decoupling queue.
	ufpd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (q_push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_entry (rd_entry),
		.q_empty  (q_empty)
	);

	// Result expansion and output register.
	ufpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_entry   (rd_entry),
		.q_pop     (q_pop),
		.pop       (pop),
		.empty     (empty),
		.kind      (kind),
		.out_byte  (out_byte),
		.has_value (has_value),
		.last      (last)
	);

endmodule
